// ===== rtl/core/prefix_code_letter_decoder_macros.svh =====
// Assertion macros shared by the prefix code letter decoder modules.
// Depends on signals named clk and rst_n in the module that uses a macro.
`ifndef PREFIX_CODE_LETTER_DECODER_MACROS_SVH
`define PREFIX_CODE_LETTER_DECODER_MACROS_SVH
`ifndef SYNTH
`define PCLD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PCLD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCLD_ASSERT_IMP(lbl, ante, cons, msg)
`define PCLD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/pcld_pkg.sv =====
// Package of the prefix code letter decoder: code table, lookup and queue entry type.
// Used by all modules of the decoder; depends on nothing.
`timescale 1ns / 1ps
package pcld_pkg;

  localparam int SymbolCount = 27;
  localparam int SymW        = 5;
  localparam int CodeW       = 10;
  localparam int MaxBitsW    = 17;
  localparam int MaxCntW     = 5;
  localparam logic [SymW-1:0] EndMark = 5'd26;

  localparam logic [CodeW-1:0] CodeValue [SymbolCount] = '{
    10'h001, 10'h00F, 10'h016, 10'h000, 10'h003, 10'h01B, 10'h00C, 10'h009, 10'h004,
    10'h0CB, 10'h064, 10'h001, 10'h018, 10'h005, 10'h002, 10'h00E, 10'h328, 10'h00A,
    10'h008, 10'h007, 10'h017, 10'h033, 10'h01A, 10'h329, 10'h00D, 10'h32A, 10'h32B
  };

  localparam logic [MaxCntW-1:0] CodeLength [SymbolCount] = '{
    5'd4, 5'd6, 5'd5, 5'd5, 5'd3, 5'd5, 5'd6, 5'd4, 5'd4,
    5'd8, 5'd7, 5'd5, 5'd5, 5'd4, 5'd4, 5'd6, 5'd10, 5'd4,
    5'd4, 5'd3, 5'd5, 5'd6, 5'd5, 5'd10, 5'd6, 5'd10, 5'd10
  };

  typedef struct packed {
    logic            hit;
    logic [SymW-1:0] sym;
  } find_t;

  typedef struct packed {
    logic            two;
    logic [SymW-1:0] sym0;
    logic            err0;
    logic [SymW-1:0] sym1;
    logic            err1;
  } entry_t;

  function automatic find_t find_symbol(input logic [MaxBitsW-1:0] bits,
                                        input logic [MaxCntW-1:0] cnt);
    find_t f;
    f = '0;
    for (int s = SymbolCount - 1; s >= 0; s--) begin
      if (CodeLength[s] == cnt && MaxBitsW'(CodeValue[s]) == bits) begin
        f.hit = 1'b1;
        f.sym = SymW'(s);
      end
    end
    return f;
  endfunction

endpackage

// ===== rtl/core/pcld_fifo.sv =====
// Short queue of decoded digit entries between the front and back parts.
// Depends on pcld_pkg for the entry type.
`timescale 1ns / 1ps
module pcld_fifo #(
  parameter int Depth = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pcld_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output pcld_pkg::entry_t head
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  pcld_pkg::entry_t mem_r [Depth];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(Depth));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/pcld_front.sv =====
// Front part: accepts digits, shifts their bits through the code matcher, builds entries.
// Depends on pcld_pkg for the code table, lookup and entry type.
`timescale 1ns / 1ps
module pcld_front #(
  parameter int MaxCodeLen = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tuser,
  input  logic             q_full,
  output logic             q_push,
  output pcld_pkg::entry_t q_entry
);

  localparam int GW   = MaxCodeLen + 1;
  localparam int CNTW = $clog2(MaxCodeLen + 2);

  logic [GW-1:0]   bits_r, bits_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            halted_r, halted_nxt;
  logic            accept;
  logic [1:0]      n_res;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && (n_res != 2'd0);

  always_comb begin
    pcld_pkg::find_t f;
    logic [GW-1:0]   b;
    logic [CNTW-1:0] c;
    logic            h;
    logic [1:0]      n;
    pcld_pkg::entry_t e;
    f = '0;
    if (in_tuser) begin
      b = '0;
      c = '0;
      h = 1'b0;
    end else begin
      b = bits_r;
      c = count_r;
      h = halted_r;
    end
    n = 2'd0;
    e = '0;
    for (int i = 3; i >= 0; i--) begin
      if (!h && n != 2'd2) begin
        b = {b[GW-2:0], in_tdata[i]};
        c = c + CNTW'(1);
        f = pcld_pkg::find_symbol(pcld_pkg::MaxBitsW'(b), pcld_pkg::MaxCntW'(c));
        if (f.hit) begin
          if (n == 2'd0) begin
            e.sym0 = f.sym;
          end else begin
            e.sym1 = f.sym;
          end
          n = n + 2'd1;
          b = '0;
          c = '0;
          if (f.sym == pcld_pkg::EndMark) begin
            h = 1'b1;
          end
        end else if (c > CNTW'(MaxCodeLen)) begin
          if (n == 2'd0) begin
            e.err0 = 1'b1;
          end else begin
            e.err1 = 1'b1;
          end
          n = n + 2'd1;
          b = '0;
          c = '0;
          h = 1'b1;
        end
      end
    end
    e.two      = (n == 2'd2);
    n_res      = n;
    q_entry    = e;
    bits_nxt   = b;
    count_nxt  = c;
    halted_nxt = h;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r   <= '0;
      count_r  <= '0;
      halted_r <= 1'b0;
    end else if (accept) begin
      bits_r   <= bits_nxt;
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// ===== rtl/core/pcld_back.sv =====
// Back part: takes entries from the queue and sends their results one per item.
// Depends on pcld_pkg for the entry type and on the assertion macro header.
`timescale 1ns / 1ps
`include "prefix_code_letter_decoder_macros.svh"
module pcld_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  pcld_pkg::entry_t q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);

  logic                      valid_r, valid_nxt;
  logic                      half_r, half_nxt;
  logic [pcld_pkg::SymW-1:0] sym_r, sym_nxt;
  logic                      err_r, err_nxt;
  logic                      last_r, last_nxt;
  logic                      load;

  assign load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    half_nxt  = half_r;
    sym_nxt   = sym_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (load) begin
      if (half_r) begin
        valid_nxt = 1'b1;
        sym_nxt   = q_head.sym1;
        err_nxt   = q_head.err1;
        last_nxt  = 1'b1;
        half_nxt  = 1'b0;
        q_pop     = 1'b1;
      end else if (!q_empty) begin
        valid_nxt = 1'b1;
        sym_nxt   = q_head.sym0;
        err_nxt   = q_head.err0;
        last_nxt  = !q_head.two;
        half_nxt  = q_head.two;
        q_pop     = !q_head.two;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r  <= sym_nxt;
    err_r  <= err_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, sym_r};
  assign out_tuser  = err_r;
  assign out_tlast  = last_r;

  `PCLD_ASSERT_IMP(a_err_form, valid_r && err_r, sym_r == '0 && last_r, "error result malformed")
  `PCLD_ASSERT_IMP(a_end_last, valid_r && sym_r == pcld_pkg::EndMark, last_r, "end mark not last")
  `PCLD_ASSERT_IMP(a_half_first, half_r, valid_r && !last_r, "second result without first")
  `PCLD_ASSERT_IMP(a_half_head, half_r, !q_empty, "second result but queue empty")
  `PCLD_ASSERT_NXT(a_sym_range, 1'b1, !valid_r || sym_r <= pcld_pkg::EndMark, "symbol out of range")

endmodule

// ===== rtl/core/prefix_code_letter_decoder.sv =====
// Top level of the prefix code letter decoder: front, entry queue and back part.
// Depends on pcld_pkg, pcld_fifo, pcld_front and pcld_back.
//
//   channel | direction | tdata             | tuser            | tlast
//   in_     | slave     | [3:0] digit       | new_transmission | -
//   out_    | master    | [4:0] symbol      | error            | last
//
// One digit is accepted per cycle while the entry queue has room; its bits are
// matched against the code table in the accept cycle until an end mark or an error halts matching.
// Results leave one per cycle from the output register while out_tready is high, so a
// digit with two results holds the back part for both results and the queue absorbs the difference.
// From accept, a digit's first result passes through the entry queue and then the output register.
// Reset is synchronous and active low.
`timescale 1ns / 1ps
module prefix_code_letter_decoder #(
  parameter int MaxCodeLen = 10,
  parameter int QueueDepth = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] digit, [7:4] zero
  input  logic       in_tuser,   // [0] new_transmission
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [4:0] symbol, [7:5] zero
  output logic       out_tuser,  // [0] error
  output logic       out_tlast
);

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  pcld_pkg::entry_t q_entry;
  pcld_pkg::entry_t q_head;

  pcld_front #(
    .MaxCodeLen (MaxCodeLen)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  pcld_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  pcld_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
